// ----- src/brb_pkg.sv -----
// Shared types and constants of the burst byte ring buffer.
// Used by the channel interfaces, the lane, merge and top-level modules.
`timescale 1ns / 1ps
package brb_pkg;

	localparam int DATA_W  = 64;
	localparam int CNT_W   = 4;
	localparam int OCC_W   = 13;
	localparam int ST_W    = 2;
	localparam int OP_W    = 2;
	localparam int BANKS   = 8;
	localparam int BANK_W  = 3;
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;

	// operation codes
	localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
	localparam logic [OP_W-1:0] OP_POP   = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
	localparam logic [OP_W-1:0] OP_START = 2'd3;

	// result status codes
	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_STOPPED = 2'd1;
	localparam logic [ST_W-1:0] ST_NOROOM  = 2'd2;
	localparam logic [ST_W-1:0] ST_EMPTY   = 2'd3;

	// register word index
	localparam logic [0:0] REG_CAPACITY = 1'b0;

	localparam logic [OCC_W-1:0] CAP_RESET = 13'd4096;

	// write command to every bank lane
	typedef struct packed {
		logic             en;
		logic [CNT_W-1:0] cnt;
	} lane_wr_t;

endpackage

// ----- src/brb_ifs.sv -----
// Valid/ready channel interfaces: request beats in, result beats out.
// Depends on brb_pkg for the field widths.
`timescale 1ns / 1ps
interface brb_req_if;
	logic                           valid;
	logic                           ready;
	logic [brb_pkg::OP_W-1:0]       op;
	logic [brb_pkg::CNT_W-1:0]      count;
	logic [brb_pkg::DATA_W-1:0]     data_in;
	logic                           stop;

	modport source (output valid, op, count, data_in, stop, input ready);
	modport sink (input valid, op, count, data_in, stop, output ready);
endinterface

interface brb_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [brb_pkg::ST_W-1:0]       status;
	logic [brb_pkg::CNT_W-1:0]      count_done;
	logic [brb_pkg::DATA_W-1:0]     data_out;
	logic [brb_pkg::OCC_W-1:0]      occupancy;

	modport source (output valid, status, count_done, data_out, occupancy, input ready);
	modport sink (input valid, status, count_done, data_out, occupancy, output ready);
endinterface

// ----- src/brb_lane.sv -----
// One byte bank of the ring store: takes its byte of a push burst and reads
// its byte of the next pop burst. Depends on brb_pkg.
`timescale 1ns / 1ps
module brb_lane #(
	parameter int AW   = 12,
	parameter int LANE = 0
) (
	input  logic                       clk,
	input  brb_pkg::lane_wr_t          wr,
	input  logic [AW-1:0]              wr_ptr,
	input  logic [brb_pkg::DATA_W-1:0] wdata,
	input  logic [AW-1:0]              rd_ptr,
	output logic [7:0]                 rbyte
);
	localparam int RW   = AW - brb_pkg::BANK_W;
	localparam int ROWS = 2 ** RW;
	localparam logic [brb_pkg::BANK_W-1:0] ME = brb_pkg::BANK_W'(LANE);

	logic [7:0] mem [ROWS];
	logic [brb_pkg::BANK_W-1:0] wk;
	logic [RW-1:0] wrow, rrow;
	logic          we;
	logic [7:0]    rbyte_q;

	// offset of this bank inside the burst, and the row after a wrap of the bank index
	assign wk   = ME - wr_ptr[brb_pkg::BANK_W-1:0];
	assign wrow = wr_ptr[AW-1:brb_pkg::BANK_W] + RW'(ME < wr_ptr[brb_pkg::BANK_W-1:0]);
	assign rrow = rd_ptr[AW-1:brb_pkg::BANK_W] + RW'(ME < rd_ptr[brb_pkg::BANK_W-1:0]);
	assign we   = wr.en && ({1'b0, wk} < wr.cnt);

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wrow] <= wdata[{wk, 3'b000} +: 8];
		end
		rbyte_q <= mem[rrow];
	end

	assign rbyte = rbyte_q;
endmodule

// ----- src/brb_merge.sv -----
// Merging stage: rotates the bank bytes into burst order and zeroes unused lanes.
// Depends on brb_pkg.
`timescale 1ns / 1ps
module brb_merge (
	input  logic [7:0]                 lane_byte [brb_pkg::BANKS],
	input  logic [brb_pkg::BANK_W-1:0] base,
	input  logic [brb_pkg::CNT_W-1:0]  n,
	output logic [brb_pkg::DATA_W-1:0] data
);
	always_comb begin
		logic [brb_pkg::BANK_W-1:0] sel;
		data = '0;
		for (int j = 0; j < brb_pkg::BANKS; j++) begin
			sel = base + brb_pkg::BANK_W'(j);
			if (brb_pkg::CNT_W'(j) < n) begin
				data[8*j +: 8] = lane_byte[sel];
			end
		end
	end
endmodule

// ----- src/byte_ring_buffer_burst.sv -----
// Top level of the burst byte ring buffer: control, occupancy, APB register.
// Depends on brb_pkg, brb_ifs, brb_lane and brb_merge.
`timescale 1ns / 1ps
// Usage:
//   req channel carries one operation per beat: push a burst of up to MAX_BURST
//   bytes (all or nothing), pop up to count bytes, clear (optionally stop), start.
//   rsp channel returns exactly one result beat per request: status, bytes done,
//   popped data (first byte in bits 7:0) and occupancy after the operation.
//   APB register 0 (byte address 0) holds capacity; writing it empties the queue
//   and sets it running. Write only while no request is in flight.
// Timing:
//   A result is registered from the accepted request held in the request registers.
//   A new request is not taken until the last one has finished: the banked store read
//   registered at the accept is used when the request finishes, and the pointers
//   settle before the next read is issued.
//   A request is still accepted while an earlier result waits on rsp; its
//   processing then holds until that result is taken.
// Reset:
//   Empty, running, capacity 4096. The byte store needs no clearing pass, so
//   the block takes requests as soon as reset is released.
module byte_ring_buffer_burst #(
	parameter int DEPTH     = 4096,
	parameter int MAX_BURST = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	brb_req_if.sink                     req,
	brb_rsp_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [brb_pkg::APB_AW-1:0]  paddr,
	input  logic [brb_pkg::APB_DW-1:0]  pwdata,
	output logic [brb_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);
	localparam int AW = $clog2(DEPTH);
	localparam logic [brb_pkg::CNT_W-1:0] MB = brb_pkg::CNT_W'(MAX_BURST);
	localparam logic [brb_pkg::OCC_W-1:0] DEPTH_CAP =
		(DEPTH > 8191) ? 13'd8191 : brb_pkg::OCC_W'(DEPTH);

	// control state
	logic [brb_pkg::OCC_W-1:0] cap_q, occ_q;
	logic [AW-1:0]             wr_ptr_q, rd_ptr_q;
	logic                      running_q, busy_q, out_valid_q;

	// accepted request
	logic [brb_pkg::OP_W-1:0]   op_s1;
	logic [brb_pkg::CNT_W-1:0]  cnt_s1;
	logic [brb_pkg::DATA_W-1:0] data_s1;
	logic                       stop_s1;

	// result register
	logic [brb_pkg::ST_W-1:0]   status_q;
	logic [brb_pkg::CNT_W-1:0]  done_q;
	logic [brb_pkg::DATA_W-1:0] dout_q;

	logic accept, fin, cfg_wr;
	logic [brb_pkg::CNT_W-1:0]  cnt_sat;
	logic [brb_pkg::OCC_W-1:0]  cap_eff, free, occ_nxt;
	logic [brb_pkg::ST_W-1:0]   st;
	logic [brb_pkg::CNT_W-1:0]  done, pop_n;
	logic                       push_ok, pop_ok;
	brb_pkg::lane_wr_t          lane_wr;
	logic [7:0]                 lane_byte [brb_pkg::BANKS];
	logic [brb_pkg::DATA_W-1:0] pop_data;

	assign accept  = req.valid && req.ready;
	assign fin     = busy_q && (!out_valid_q || rsp.ready);
	assign cfg_wr  = psel && penable && pwrite && (paddr[2] == brb_pkg::REG_CAPACITY);
	assign cnt_sat = (req.count > MB) ? MB : req.count;

	assign req.ready = !busy_q;
	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == brb_pkg::REG_CAPACITY) ?
		{{(brb_pkg::APB_DW - brb_pkg::OCC_W){1'b0}}, cap_q} : '0;

	assign cap_eff = (cap_q == '0) ? brb_pkg::OCC_W'(1) :
		((cap_q > DEPTH_CAP) ? DEPTH_CAP : cap_q);
	assign free = cap_eff - occ_q;

	always_comb begin
		st      = brb_pkg::ST_OK;
		done    = '0;
		push_ok = 1'b0;
		pop_ok  = 1'b0;
		pop_n   = ({{(brb_pkg::OCC_W - brb_pkg::CNT_W){1'b0}}, cnt_s1} < occ_q) ?
			cnt_s1 : occ_q[brb_pkg::CNT_W-1:0];
		occ_nxt = occ_q;
		case (op_s1)
			brb_pkg::OP_PUSH: begin
				if (!running_q) begin
					st = brb_pkg::ST_STOPPED;
				end else if (cnt_s1 != '0) begin
					if (free < {{(brb_pkg::OCC_W - brb_pkg::CNT_W){1'b0}}, cnt_s1}) begin
						st = brb_pkg::ST_NOROOM;
					end else begin
						push_ok = 1'b1;
						done    = cnt_s1;
						occ_nxt = occ_q + brb_pkg::OCC_W'(cnt_s1);
					end
				end
			end
			brb_pkg::OP_POP: begin
				if (!running_q) begin
					st = brb_pkg::ST_STOPPED;
				end else if (occ_q == '0) begin
					st = brb_pkg::ST_EMPTY;
				end else if (cnt_s1 != '0) begin
					pop_ok  = 1'b1;
					done    = pop_n;
					occ_nxt = occ_q - brb_pkg::OCC_W'(pop_n);
				end
			end
			brb_pkg::OP_CLEAR: occ_nxt = '0;
			brb_pkg::OP_START: occ_nxt = occ_q;
			default: occ_nxt = occ_q;
		endcase
	end

	assign lane_wr.en  = fin && push_ok;
	assign lane_wr.cnt = cnt_s1;

	for (genvar g = 0; g < brb_pkg::BANKS; g++) begin : g_lane
		brb_lane #(
			.AW   (AW),
			.LANE (g)
		) u_lane (
			.clk    (clk),
			.wr     (lane_wr),
			.wr_ptr (wr_ptr_q),
			.wdata  (data_s1),
			.rd_ptr (rd_ptr_q),
			.rbyte  (lane_byte[g])
		);
	end

	brb_merge u_merge (
		.lane_byte (lane_byte),
		.base      (rd_ptr_q[brb_pkg::BANK_W-1:0]),
		.n         (pop_ok ? pop_n : '0),
		.data      (pop_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= brb_pkg::CAP_RESET;
			occ_q       <= '0;
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			running_q   <= 1'b1;
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (fin) begin
				busy_q <= 1'b0;
			end
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_wr) begin
				cap_q     <= pwdata[brb_pkg::OCC_W-1:0];
				occ_q     <= '0;
				wr_ptr_q  <= '0;
				rd_ptr_q  <= '0;
				running_q <= 1'b1;
			end else if (fin) begin
				occ_q <= occ_nxt;
				if (push_ok) begin
					wr_ptr_q <= wr_ptr_q + AW'(cnt_s1);
				end
				if (pop_ok) begin
					rd_ptr_q <= rd_ptr_q + AW'(pop_n);
				end
				if (op_s1 == brb_pkg::OP_CLEAR) begin
					wr_ptr_q <= '0;
					rd_ptr_q <= '0;
					if (stop_s1) begin
						running_q <= 1'b0;
					end
				end
				if (op_s1 == brb_pkg::OP_START) begin
					running_q <= 1'b1;
				end
			end
		end
	end

	// payload registers: hold the request and the result until used
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= req.op;
			cnt_s1  <= cnt_sat;
			data_s1 <= req.data_in;
			stop_s1 <= req.stop;
		end
		if (fin) begin
			status_q <= st;
			done_q   <= done;
			dout_q   <= pop_data;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.status     = status_q;
	assign rsp.count_done = done_q;
	assign rsp.data_out   = dout_q;

	// occupancy after the op is the current count while a result is shown
	logic [brb_pkg::OCC_W-1:0] occ_out_q;
	always_ff @(posedge clk) begin
		if (fin) begin
			occ_out_q <= cfg_wr ? '0 : occ_nxt;
		end
	end
	assign rsp.occupancy = occ_out_q;
endmodule
